>>> rtl/sofl_pkg.sv
// ---------------------------------------------------------------------------
// Sigma outlier frame flagger: shared package
// Sizes, command and status codes, and the payload structs of both channels.
// ---------------------------------------------------------------------------
package sofl_pkg;

    // Capacity of the sample store and width of one stored sample.
    localparam int MAX_FRAMES  = 1024;
    localparam int SAMPLE_BITS = 16;

    // Derived widths. The frame count must be able to hold MAX_FRAMES itself.
    localparam int ADDR_W = $clog2(MAX_FRAMES);
    localparam int CNT_W  = $clog2(MAX_FRAMES + 1);
    localparam int SUM_W  = SAMPLE_BITS + CNT_W - 1;
    localparam int SQS_W  = 2 * SAMPLE_BITS + CNT_W - 1;
    localparam int VAR_W  = SQS_W + CNT_W - 1;

    // Fixed field widths of the channels.
    localparam int CMD_W    = 2;
    localparam int IN_SMP_W = 16;
    localparam int STAT_W   = 2;
    localparam int IDX_W    = 10;
    localparam int THR_W    = 8;

    // Threshold after reset: 3.0 in unsigned Q4.4.
    localparam logic [THR_W-1:0] THR_RESET = 8'd48;

    // Command codes.
    localparam logic [CMD_W-1:0] CMD_LOAD  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_EVAL  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_FETCH = 2'd2;
    localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd3;

    // Status codes.
    localparam logic [STAT_W-1:0] STAT_OK    = 2'd0;
    localparam logic [STAT_W-1:0] STAT_FULL  = 2'd1;
    localparam logic [STAT_W-1:0] STAT_NONE  = 2'd2;
    localparam logic [STAT_W-1:0] STAT_EMPTY = 2'd3;

    // One command transfer.
    typedef struct packed {
        logic [CMD_W-1:0]    cmd;
        logic [IN_SMP_W-1:0] sample;
    } t_in;

    // One result transfer.
    typedef struct packed {
        logic [STAT_W-1:0] status;
        logic [IDX_W-1:0]  frame_index;
    } t_out;

endpackage

>>> rtl/sofl_ram.sv
// ---------------------------------------------------------------------------
// Sigma outlier frame flagger: generic RAM
// Simple dual-port RAM, one write port and one read port with registered read.
// ---------------------------------------------------------------------------
module sofl_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write port and registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

>>> rtl/sigma_outlier_frame_flagger_top.sv
// ---------------------------------------------------------------------------
// Sigma outlier frame flagger: top level
// Stores per-frame median samples and flags frames beyond k sigma of the run.
// ---------------------------------------------------------------------------
// Usage:
// A command transfer happens at a rising edge with start high and busy low.
// Every command gives exactly one result, shown on o_result for one cycle
// while o_result_valid is high; the receiver cannot stall it.
// Clear, a load into a full store, an evaluate or fetch on an empty run and
// a fetch before evaluate answer in the cycle after the transfer.
// A load goes through S_LOAD, which writes the sample RAM and updates both
// running sums; busy stays high there, so a new load waits until idle.
// Evaluate forms the partial products of n*S2 and S*S in S_EV_MUL, then
// the subtraction that forms the variance numerator in S_EV_SUB.
// A fetch forms k*k*V in S_F_K2, S_F_PART and S_F_RHS, then examines each
// frame in turn (RAM read, n*x-S, square, compare), and ends the scan in
// S_F_RD when no outlier is left; a frame is read after the last compare.
// The threshold register is always ready, written via i_cfg_valid/o_cfg_ready;
// users change it only while the block is idle; the block does not enforce it.
// Reset empties the run, clears the result strobe and sets the threshold
// to 3.0. The sample RAM is not cleared: only entries of the current run
// are ever read.
// ---------------------------------------------------------------------------
module sigma_outlier_frame_flagger_top (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  sofl_pkg::t_in                 i_item,
    output logic                          o_result_valid,
    output sofl_pkg::t_out                o_result,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [sofl_pkg::THR_W-1:0]    i_cfg_data
);

    localparam int ADDR_W = sofl_pkg::ADDR_W;
    localparam int CNT_W  = sofl_pkg::CNT_W;
    localparam int SB     = sofl_pkg::SAMPLE_BITS;
    localparam int SUM_W  = sofl_pkg::SUM_W;
    localparam int SQS_W  = sofl_pkg::SQS_W;
    localparam int VAR_W  = sofl_pkg::VAR_W;
    localparam int THR_W  = sofl_pkg::THR_W;
    localparam int IDX_W  = sofl_pkg::IDX_W;
    localparam int IN_W   = sofl_pkg::IN_SMP_W;
    localparam int K2_W   = 2 * THR_W;
    localparam int SQL_W  = SQS_W / 2;
    localparam int SQH_W  = SQS_W - SQL_W;
    localparam int VL_W   = VAR_W / 2;
    localparam int VH_W   = VAR_W - VL_W;
    localparam int PW     = CNT_W + SQS_W;
    localparam int NX_W   = CNT_W + SB;
    localparam int CMP_W  = VAR_W + K2_W;

    // Sequencer states.
    typedef enum logic [10:0] {
        S_IDLE    = 11'b000_0000_0001,
        S_LOAD    = 11'b000_0000_0010,
        S_EV_MUL  = 11'b000_0000_0100,
        S_EV_SUB  = 11'b000_0000_1000,
        S_F_K2    = 11'b000_0001_0000,
        S_F_PART  = 11'b000_0010_0000,
        S_F_RHS   = 11'b000_0100_0000,
        S_F_RD    = 11'b000_1000_0000,
        S_F_MUL   = 11'b001_0000_0000,
        S_F_SQ    = 11'b010_0000_0000,
        S_F_CMP   = 11'b100_0000_0000
    } t_state;

    // Frame index of a cursor value, kept to the low bits of the result field.
    function automatic logic [IDX_W-1:0] to_index(input logic [CNT_W-1:0] v);
        logic [CNT_W+IDX_W-1:0] ext;
        ext = {{IDX_W{1'b0}}, v};
        return ext[IDX_W-1:0];
    endfunction

    // Control state.
    t_state               r_state, n_state;
    logic [CNT_W-1:0]     r_count, n_count;
    logic [SUM_W-1:0]     r_sum, n_sum;
    logic [SQS_W-1:0]     r_sqsum, n_sqsum;
    logic [VAR_W-1:0]     r_var, n_var;
    logic [CNT_W-1:0]     r_cursor, n_cursor;
    logic                 r_stats_ok, n_stats_ok;
    logic [THR_W-1:0]     r_thresh, n_thresh;
    logic                 r_result_valid, n_result_valid;

    // Payload and datapath registers.
    sofl_pkg::t_out       r_result, n_result;
    logic [SB-1:0]        r_x, n_x;
    logic [CNT_W+SQL_W-1:0] r_p_lo, n_p_lo;
    logic [CNT_W+SQH_W-1:0] r_p_hi, n_p_hi;
    logic [2*SUM_W-1:0]   r_ssq, n_ssq;
    logic [K2_W-1:0]      r_k2, n_k2;
    logic [VL_W+K2_W-1:0] r_v_lo, n_v_lo;
    logic [VH_W+K2_W-1:0] r_v_hi, n_v_hi;
    logic [CMP_W-1:0]     r_rhs, n_rhs;
    logic [SUM_W-1:0]     r_d, n_d;
    logic [2*SUM_W-1:0]   r_dsq, n_dsq;

    // RAM port signals.
    logic                 ram_we;
    logic [SB-1:0]        ram_rdata;

    // Helper values.
    logic                 accept;
    logic [IN_W+SB-1:0]   smp_ext;
    logic [PW-1:0]        ns2;
    logic [PW-1:0]        vdiff;
    logic [NX_W-1:0]      nx;
    logic [NX_W-1:0]      sum_ext;
    logic [NX_W-1:0]      dabs;
    logic [CMP_W-1:0]     lhs;

    assign accept      = start && !busy;
    assign busy        = (r_state != S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign smp_ext     = {{SB{1'b0}}, i_item.sample};

    // Datapath terms shared by the sequencer.
    assign ns2     = (PW'(r_p_hi) << SQL_W) + PW'(r_p_lo);
    assign vdiff   = ns2 - PW'(r_ssq);
    assign nx      = NX_W'(r_count) * NX_W'(ram_rdata);
    assign sum_ext = NX_W'(r_sum);
    assign dabs    = (nx >= sum_ext) ? (nx - sum_ext) : (sum_ext - nx);
    assign lhs     = CMP_W'(r_dsq) << 8;

    // Sample store.
    sofl_ram #(
        .WIDTH (SB),
        .DEPTH (sofl_pkg::MAX_FRAMES)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_count[ADDR_W-1:0]),
        .i_wdata (r_x),
        .i_raddr (r_cursor[ADDR_W-1:0]),
        .o_rdata (ram_rdata)
    );

    // Command sequencer and next-state logic.
    always_comb begin
        n_state        = r_state;
        n_count        = r_count;
        n_sum          = r_sum;
        n_sqsum        = r_sqsum;
        n_var          = r_var;
        n_cursor       = r_cursor;
        n_stats_ok     = r_stats_ok;
        n_thresh       = r_thresh;
        n_result_valid = 1'b0;
        n_result       = r_result;
        n_x            = r_x;
        n_p_lo         = r_p_lo;
        n_p_hi         = r_p_hi;
        n_ssq          = r_ssq;
        n_k2           = r_k2;
        n_v_lo         = r_v_lo;
        n_v_hi         = r_v_hi;
        n_rhs          = r_rhs;
        n_d            = r_d;
        n_dsq          = r_dsq;
        ram_we         = 1'b0;

        if (i_cfg_valid) begin
            n_thresh = i_cfg_data;
        end

        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_result.status      = sofl_pkg::STAT_OK;
                    n_result.frame_index = '0;
                    unique case (i_item.cmd)
                        sofl_pkg::CMD_LOAD: begin
                            n_x = smp_ext[SB-1:0];
                            if (r_count >= CNT_W'(sofl_pkg::MAX_FRAMES)) begin
                                n_result.status = sofl_pkg::STAT_FULL;
                                n_result_valid  = 1'b1;
                            end else begin
                                n_state = S_LOAD;
                            end
                        end
                        sofl_pkg::CMD_EVAL: begin
                            if (r_count == '0) begin
                                n_stats_ok      = 1'b0;
                                n_result.status = sofl_pkg::STAT_EMPTY;
                                n_result_valid  = 1'b1;
                            end else begin
                                n_state = S_EV_MUL;
                            end
                        end
                        sofl_pkg::CMD_FETCH: begin
                            if (r_count == '0) begin
                                n_result.status = sofl_pkg::STAT_EMPTY;
                                n_result_valid  = 1'b1;
                            end else if (!r_stats_ok) begin
                                n_result.status = sofl_pkg::STAT_NONE;
                                n_result_valid  = 1'b1;
                            end else begin
                                n_state = S_F_K2;
                            end
                        end
                        sofl_pkg::CMD_CLEAR: begin
                            // Clear starts a new run; the RAM keeps stale data.
                            n_count        = '0;
                            n_sum          = '0;
                            n_sqsum        = '0;
                            n_var          = '0;
                            n_cursor       = '0;
                            n_stats_ok     = 1'b0;
                            n_result_valid = 1'b1;
                        end
                    endcase
                end
            end

            S_LOAD: begin
                // Store the sample and fold it into both running sums.
                ram_we               = 1'b1;
                n_sum                = r_sum + SUM_W'(r_x);
                n_sqsum              = r_sqsum + SQS_W'(r_x) * SQS_W'(r_x);
                n_count              = r_count + 1'b1;
                n_stats_ok           = 1'b0;
                n_result.status      = sofl_pkg::STAT_OK;
                n_result.frame_index = to_index(r_count);
                n_result_valid       = 1'b1;
                n_state              = S_IDLE;
            end

            S_EV_MUL: begin
                // Partial products of n*S2, and S*S.
                n_p_lo  = (CNT_W+SQL_W)'(r_count) * (CNT_W+SQL_W)'(r_sqsum[SQL_W-1:0]);
                n_p_hi  = (CNT_W+SQH_W)'(r_count) * (CNT_W+SQH_W)'(r_sqsum[SQS_W-1:SQL_W]);
                n_ssq   = (2*SUM_W)'(r_sum) * (2*SUM_W)'(r_sum);
                n_state = S_EV_SUB;
            end

            S_EV_SUB: begin
                n_var           = vdiff[VAR_W-1:0];
                n_cursor        = '0;
                n_stats_ok      = 1'b1;
                n_result.status = sofl_pkg::STAT_OK;
                n_result_valid  = 1'b1;
                n_state         = S_IDLE;
            end

            S_F_K2: begin
                n_k2    = K2_W'(r_thresh) * K2_W'(r_thresh);
                n_state = S_F_PART;
            end

            S_F_PART: begin
                // Split k*k*V into two narrower products.
                n_v_lo  = (VL_W+K2_W)'(r_var[VL_W-1:0]) * (VL_W+K2_W)'(r_k2);
                n_v_hi  = (VH_W+K2_W)'(r_var[VAR_W-1:VL_W]) * (VH_W+K2_W)'(r_k2);
                n_state = S_F_RHS;
            end

            S_F_RHS: begin
                n_rhs   = (CMP_W'(r_v_hi) << VL_W) + CMP_W'(r_v_lo);
                n_state = S_F_RD;
            end

            S_F_RD: begin
                // The RAM read of the cursor entry is issued in this cycle.
                if (r_cursor >= r_count) begin
                    n_result.status = sofl_pkg::STAT_NONE;
                    n_result_valid  = 1'b1;
                    n_state         = S_IDLE;
                end else begin
                    n_state = S_F_MUL;
                end
            end

            S_F_MUL: begin
                n_d     = dabs[SUM_W-1:0];
                n_state = S_F_SQ;
            end

            S_F_SQ: begin
                n_dsq   = (2*SUM_W)'(r_d) * (2*SUM_W)'(r_d);
                n_state = S_F_CMP;
            end

            S_F_CMP: begin
                // Exact test: 256*(n*x-S)^2 > K*K*V.
                n_cursor = r_cursor + 1'b1;
                if (lhs > r_rhs) begin
                    n_result.status      = sofl_pkg::STAT_OK;
                    n_result.frame_index = to_index(r_cursor);
                    n_result_valid       = 1'b1;
                    n_state              = S_IDLE;
                end else begin
                    n_state = S_F_RD;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= S_IDLE;
            r_count        <= '0;
            r_sum          <= '0;
            r_sqsum        <= '0;
            r_var          <= '0;
            r_cursor       <= '0;
            r_stats_ok     <= 1'b0;
            r_thresh       <= sofl_pkg::THR_RESET;
            r_result_valid <= 1'b0;
        end else begin
            r_state        <= n_state;
            r_count        <= n_count;
            r_sum          <= n_sum;
            r_sqsum        <= n_sqsum;
            r_var          <= n_var;
            r_cursor       <= n_cursor;
            r_stats_ok     <= n_stats_ok;
            r_thresh       <= n_thresh;
            r_result_valid <= n_result_valid;
        end
    end

    // Payload and datapath registers.
    always_ff @(posedge i_clk) begin
        r_result <= n_result;
        r_x      <= n_x;
        r_p_lo   <= n_p_lo;
        r_p_hi   <= n_p_hi;
        r_ssq    <= n_ssq;
        r_k2     <= n_k2;
        r_v_lo   <= n_v_lo;
        r_v_hi   <= n_v_hi;
        r_rhs    <= n_rhs;
        r_d      <= n_d;
        r_dsq    <= n_dsq;
    end

    assign o_result_valid = r_result_valid;
    assign o_result       = r_result;

endmodule

>>> bench/tb_top.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// Sigma outlier frame flagger: testbench
// Sends load, evaluate, fetch and clear commands over the start/busy port
// and checks every result against a cycle-free model of the run statistics.
// The threshold is changed between phases while the block is idle, and
// idle gaps on the sending side are drawn at random per phase.
// ---------------------------------------------------------------------------
module tb_top;

    localparam int WATCHDOG_LIMIT = 40000;
    localparam int PHASE_ITEMS    = 12;
    localparam int PHASES         = 8;

    // Clock, reset and the ports of the block.
    logic                          i_clk       = 1'b0;
    logic                          i_rst_n     = 1'b0;
    logic                          start       = 1'b0;
    logic                          busy;
    sofl_pkg::t_in                 i_item      = '0;
    logic                          o_result_valid;
    sofl_pkg::t_out                o_result;
    logic                          i_cfg_valid = 1'b0;
    logic                          o_cfg_ready;
    logic [sofl_pkg::THR_W-1:0]    i_cfg_data  = '0;

    sigma_outlier_frame_flagger_top u_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_item         (i_item),
        .o_result_valid (o_result_valid),
        .o_result       (o_result),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_data     (i_cfg_data)
    );

    // 2 ns clock period.
    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Commands waiting to be sent and results still expected.
    sofl_pkg::t_in  cmd_queue[$];
    sofl_pkg::t_out pending_results[$];

    // Model of the run: stored samples, sums, variance numerator and scan.
    logic [sofl_pkg::SAMPLE_BITS-1:0] run_samples [0:sofl_pkg::MAX_FRAMES-1];
    logic [sofl_pkg::CNT_W-1:0]       run_count;
    logic [sofl_pkg::SUM_W-1:0]       run_sum;
    logic [sofl_pkg::SQS_W-1:0]       run_sqsum;
    logic [sofl_pkg::VAR_W-1:0]       run_var;
    logic [sofl_pkg::CNT_W-1:0]       run_cursor;
    logic                             run_stats_ok;
    logic [sofl_pkg::THR_W-1:0]       model_thr;

    // Sender control and bookkeeping.
    bit cmd_taken  = 1'b0;
    int gap_left   = 0;
    int idle_pct   = 0;
    int idle_cycles = 0;
    int fail_count = 0;
    int cfg_writes = 0;
    int n_loads, n_evals, n_fetches, n_clears, n_flagged, n_dropped, n_empty;
    int queued_items;
    sofl_pkg::t_out got_result, want_result;

    // Outlier test in integers: 256 * (n*x - S)^2 > K*K * V.
    function automatic bit beyond_threshold(logic [sofl_pkg::SAMPLE_BITS-1:0] x);
        logic [63:0]  nx;
        logic [63:0]  dev;
        logic [127:0] lhs;
        logic [127:0] rhs;
        nx  = 64'(run_count) * 64'(x);
        dev = (nx >= 64'(run_sum)) ? nx - 64'(run_sum) : 64'(run_sum) - nx;
        lhs = (128'(dev) * 128'(dev)) << 8;
        rhs = 128'(run_var) * (128'(model_thr) * 128'(model_thr));
        return lhs > rhs;
    endfunction

    // Applies one command to the model and returns the result it must give.
    function automatic sofl_pkg::t_out flag_model_step(sofl_pkg::t_in it);
        sofl_pkg::t_out             r;
        logic [63:0]                wx;
        logic [63:0]                wsq;
        logic [63:0]                wv;
        logic [sofl_pkg::CNT_W-1:0] idx;
        bit                         found;
        r.status      = sofl_pkg::STAT_OK;
        r.frame_index = '0;
        found         = 1'b0;
        case (it.cmd)
            sofl_pkg::CMD_LOAD: begin
                if (int'(run_count) >= sofl_pkg::MAX_FRAMES) begin
                    r.status = sofl_pkg::STAT_FULL;
                end else begin
                    wx  = 64'(it.sample[sofl_pkg::SAMPLE_BITS-1:0]);
                    wsq = wx * wx;
                    run_samples[run_count[sofl_pkg::ADDR_W-1:0]] =
                        it.sample[sofl_pkg::SAMPLE_BITS-1:0];
                    run_sum       = run_sum + wx[sofl_pkg::SUM_W-1:0];
                    run_sqsum     = run_sqsum + wsq[sofl_pkg::SQS_W-1:0];
                    r.frame_index = run_count[sofl_pkg::IDX_W-1:0];
                    run_count     = run_count + 1'b1;
                    run_stats_ok  = 1'b0;
                end
            end
            sofl_pkg::CMD_EVAL: begin
                if (run_count == '0) begin
                    run_stats_ok = 1'b0;
                    r.status     = sofl_pkg::STAT_EMPTY;
                end else begin
                    wv = 64'(run_count) * 64'(run_sqsum)
                         - 64'(run_sum) * 64'(run_sum);
                    run_var      = wv[sofl_pkg::VAR_W-1:0];
                    run_cursor   = '0;
                    run_stats_ok = 1'b1;
                end
            end
            sofl_pkg::CMD_FETCH: begin
                if (run_count == '0) begin
                    r.status = sofl_pkg::STAT_EMPTY;
                end else if (!run_stats_ok) begin
                    r.status = sofl_pkg::STAT_NONE;
                end else begin
                    // Walk on from the cursor; it parks at the count when done.
                    r.status = sofl_pkg::STAT_NONE;
                    while (run_cursor < run_count && !found) begin
                        idx        = run_cursor;
                        run_cursor = run_cursor + 1'b1;
                        if (beyond_threshold(run_samples[idx[sofl_pkg::ADDR_W-1:0]])) begin
                            found         = 1'b1;
                            r.status      = sofl_pkg::STAT_OK;
                            r.frame_index = idx[sofl_pkg::IDX_W-1:0];
                        end
                    end
                end
            end
            default: begin
                run_count    = '0;
                run_sum      = '0;
                run_sqsum    = '0;
                run_var      = '0;
                run_cursor   = '0;
                run_stats_ok = 1'b0;
            end
        endcase
        return r;
    endfunction

    // Driver: one command at a time, with random idle bursts between them.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            start <= 1'b0;
        end else if (!start || cmd_taken) begin
            cmd_taken = 1'b0;
            if (gap_left > 0) begin
                gap_left = gap_left - 1;
                start <= 1'b0;
            end else if (cmd_queue.size() > 0) begin
                i_item <= cmd_queue.pop_front();
                start  <= 1'b1;
                if (idle_pct > 0 && $urandom_range(0, 99) < idle_pct)
                    gap_left = $urandom_range(1, 16);
            end else begin
                start <= 1'b0;
            end
        end
    end

    // Monitor: checks results, predicts accepted commands, tracks the threshold.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_result_valid) begin
                got_result = o_result;
                if (pending_results.size() == 0) begin
                    $display("%0t: unexpected result status %0d index %0d", $time,
                             got_result.status, got_result.frame_index);
                    fail_count++;
                end else begin
                    want_result = pending_results.pop_front();
                    if (got_result.status != want_result.status) begin
                        $display("%0t: status mismatch, expected %0d, actual %0d", $time,
                                 want_result.status, got_result.status);
                        fail_count++;
                    end
                    if (got_result.frame_index != want_result.frame_index) begin
                        $display("%0t: frame index mismatch, expected %0d, actual %0d",
                                 $time, want_result.frame_index, got_result.frame_index);
                        fail_count++;
                    end
                end
            end

            if (start && !busy) begin
                want_result = flag_model_step(i_item);
                pending_results = {pending_results, want_result};
                cmd_taken = 1'b1;
                case (i_item.cmd)
                    sofl_pkg::CMD_LOAD:  n_loads++;
                    sofl_pkg::CMD_EVAL:  n_evals++;
                    sofl_pkg::CMD_FETCH: n_fetches++;
                    default:             n_clears++;
                endcase
                if (i_item.cmd == sofl_pkg::CMD_FETCH && want_result.status == sofl_pkg::STAT_OK)
                    n_flagged++;
                if (want_result.status == sofl_pkg::STAT_FULL) n_dropped++;
                if (want_result.status == sofl_pkg::STAT_EMPTY) n_empty++;
            end

            if (i_cfg_valid && o_cfg_ready) begin
                model_thr = i_cfg_data;
                cfg_writes++;
            end

            // Watchdog on cycles with no command or threshold transfer.
            if ((start && !busy) || (i_cfg_valid && o_cfg_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("%0t: watchdog expired with %0d results outstanding", $time,
                         pending_results.size());
                $display("simulation failed");
                $finish;
            end
        end
    end

    task automatic queue_cmd(logic [sofl_pkg::CMD_W-1:0] cmd,
                             logic [sofl_pkg::IN_SMP_W-1:0] sample);
        sofl_pkg::t_in it;
        it.cmd    = cmd;
        it.sample = sample;
        cmd_queue = {cmd_queue, it};
        queued_items++;
    endtask

    // Draws a sample anywhere in range.
    function automatic logic [sofl_pkg::IN_SMP_W-1:0] rand_sample();
        logic [31:0] rv;
        rv = $urandom();
        return rv[sofl_pkg::IN_SMP_W-1:0];
    endfunction

    // Draws a sample near a base level, sometimes anywhere in range.
    function automatic logic [sofl_pkg::IN_SMP_W-1:0] near_sample(int base, int spread);
        int v;
        if ($urandom_range(0, 11) == 0) return rand_sample();
        v = base + $urandom_range(0, spread);
        if (v > 65535) v = 65535;
        return v[sofl_pkg::IN_SMP_W-1:0];
    endfunction

    // A well-formed run: clear, loads, evaluate, fetches, with a few twists.
    task automatic queue_random_run();
        int n_frames, base, spread, n_fetch, i;
        if ($urandom_range(0, 9) != 0) queue_cmd(sofl_pkg::CMD_CLEAR, rand_sample());
        case ($urandom_range(0, 4))
            0:       spread = 0;
            1:       spread = 15;
            2:       spread = 255;
            3:       spread = 4095;
            default: spread = 65535;
        endcase
        base = $urandom_range(0, 65535);
        if ($urandom_range(0, 9) == 0)
            n_frames = 0;
        else if ($urandom_range(0, 14) == 0)
            n_frames = $urandom_range(40, 120);
        else
            n_frames = $urandom_range(1, 24);
        for (i = 0; i < n_frames; i++) begin
            queue_cmd(sofl_pkg::CMD_LOAD, near_sample(base, spread));
            if ($urandom_range(0, 40) == 0) queue_cmd(sofl_pkg::CMD_FETCH, rand_sample());
        end
        queue_cmd(sofl_pkg::CMD_EVAL, rand_sample());
        n_fetch = $urandom_range(1, 6);
        for (i = 0; i < n_fetch; i++) queue_cmd(sofl_pkg::CMD_FETCH, rand_sample());
        // A load after evaluate hides the statistics until the next evaluate.
        if ($urandom_range(0, 4) == 0) begin
            queue_cmd(sofl_pkg::CMD_LOAD, near_sample(base, spread));
            queue_cmd(sofl_pkg::CMD_FETCH, rand_sample());
            queue_cmd(sofl_pkg::CMD_EVAL, rand_sample());
            queue_cmd(sofl_pkg::CMD_FETCH, rand_sample());
        end
    endtask

    // Fills the store to capacity, overfills it, then scans it to the end.
    task automatic queue_full_store();
        int base, i, v;
        base = $urandom_range(0, 65535 - 255);
        queue_cmd(sofl_pkg::CMD_CLEAR, '0);
        for (i = 0; i < sofl_pkg::MAX_FRAMES - 1; i++) begin
            if ($urandom_range(0, 63) == 0) begin
                queue_cmd(sofl_pkg::CMD_LOAD, rand_sample());
            end else begin
                v = base + $urandom_range(0, 255);
                queue_cmd(sofl_pkg::CMD_LOAD, v[sofl_pkg::IN_SMP_W-1:0]);
            end
        end
        // The last frame is far off, so the highest index gets flagged.
        queue_cmd(sofl_pkg::CMD_LOAD, (base < 32768) ? 16'hFFFF : 16'h0000);
        for (i = 0; i < 3; i++) queue_cmd(sofl_pkg::CMD_LOAD, rand_sample());
        queue_cmd(sofl_pkg::CMD_EVAL, '0);
        for (i = 0; i < 40; i++) queue_cmd(sofl_pkg::CMD_FETCH, '0);
    endtask

    // Waits until everything sent has been answered, then lets the block settle.
    task automatic wait_idle();
        do @(posedge i_clk);
        while (cmd_queue.size() != 0 || start || gap_left != 0
               || pending_results.size() != 0);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic write_threshold(logic [sofl_pkg::THR_W-1:0] value);
        int seen;
        seen = cfg_writes;
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= value;
        wait (cfg_writes != seen);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // Stimulus: directed commands, then phases of random runs.
    initial begin
        int p, i, thr;
        logic [31:0] rc;
        n_loads = 0; n_evals = 0; n_fetches = 0; n_clears = 0;
        n_flagged = 0; n_dropped = 0; n_empty = 0; queued_items = 0;
        model_thr    = sofl_pkg::THR_RESET;
        run_count    = '0;
        run_sum      = '0;
        run_sqsum    = '0;
        run_var      = '0;
        run_cursor   = '0;
        run_stats_ok = 1'b0;

        repeat (5) @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed: empty run, fetch before evaluate, one clear outlier among
        // ten equal frames, scan exhausted, load after evaluate, clear.
        idle_pct = 25;
        queue_cmd(sofl_pkg::CMD_FETCH, 16'hFFFF);
        queue_cmd(sofl_pkg::CMD_EVAL, 16'h0000);
        queue_cmd(sofl_pkg::CMD_LOAD, 16'hFFFF);
        queue_cmd(sofl_pkg::CMD_FETCH, 16'h0000);
        for (i = 0; i < 10; i++) queue_cmd(sofl_pkg::CMD_LOAD, 16'h0000);
        queue_cmd(sofl_pkg::CMD_EVAL, 16'h0000);
        queue_cmd(sofl_pkg::CMD_FETCH, 16'h0000);
        queue_cmd(sofl_pkg::CMD_FETCH, 16'h0000);
        queue_cmd(sofl_pkg::CMD_FETCH, 16'h0000);
        queue_cmd(sofl_pkg::CMD_LOAD, 16'h5555);
        queue_cmd(sofl_pkg::CMD_FETCH, 16'h0000);
        queue_cmd(sofl_pkg::CMD_CLEAR, 16'hAAAA);
        queue_cmd(sofl_pkg::CMD_FETCH, 16'h0000);
        wait_idle();

        // Random phases, each with its own threshold and idling.
        for (p = 0; p < PHASES; p++) begin
            if (p == 0)
                thr = 0;
            else if (p == 1)
                thr = 255;
            else if (p == PHASES - 1)
                thr = int'(sofl_pkg::THR_RESET);
            else if ($urandom_range(0, 1) == 0)
                thr = $urandom_range(8, 64);
            else
                thr = $urandom_range(0, 255);
            write_threshold(thr[sofl_pkg::THR_W-1:0]);

            // The last phase runs back to back.
            if (p == PHASES - 1) begin
                idle_pct = 0;
            end else begin
                case ($urandom_range(0, 2))
                    0:       idle_pct = 0;
                    1:       idle_pct = 15;
                    default: idle_pct = 40;
                endcase
            end

            if (p == 3) queue_full_store();
            queued_items = 0;
            while (queued_items < PHASE_ITEMS) begin
                if ($urandom_range(0, 9) == 0) begin
                    rc = $urandom_range(0, 3);
                    queue_cmd(rc[sofl_pkg::CMD_W-1:0], rand_sample());
                end else begin
                    queue_random_run();
                end
            end
            wait_idle();
        end

        $display("Covered %0d loads (%0d dropped on a full store), %0d evaluates, %0d fetches,",
                 n_loads, n_dropped, n_evals, n_fetches);
        $display("%0d clears, %0d outliers flagged, %0d empty-run answers, %0d threshold writes.",
                 n_clears, n_flagged, n_empty, cfg_writes);
        if (fail_count == 0 && pending_results.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

>>> sim.f
rtl/sofl_pkg.sv
rtl/sofl_ram.sv
rtl/sigma_outlier_frame_flagger_top.sv
bench/tb_top.sv
